// File: sv/pscan_pkg.sv
// Package for the PAM site guide scanner: sizes, codes, slot types and
// the PAM symbol helpers. No dependencies.
package pscan_pkg;

    localparam int GUIDE_LEN = 19;
    localparam int PAM_MAX   = 8;
    localparam int WIN_DEPTH = GUIDE_LEN + PAM_MAX;
    localparam int BASE_W    = 3;
    localparam int POS_W     = 32;
    localparam int FILL_W    = 5;
    localparam int LEN_W     = 4;
    localparam int SYMS_W    = 24;
    localparam int GUIDE_W   = 57;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PAM_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAM_SYMBOLS = 1'b1;

    localparam logic KIND_BASE  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic [BASE_W-1:0] SYM_ANY = 3'd4;

    localparam logic [LEN_W-1:0]  PAM_LEN_RST  = 4'd3;
    localparam logic [SYMS_W-1:0] PAM_SYMS_RST = 24'd148;

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_DEPTH);
    localparam logic [POS_W-1:0]  POS_MAX  = '1;

    typedef logic [WIN_DEPTH-1:0][BASE_W-1:0] t_window;

    typedef struct packed {
        t_window           window;
        logic [FILL_W-1:0] fill;
        logic [POS_W-1:0]  pos;
    } t_slot;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

    function automatic logic [LEN_W-1:0] eff_pam_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0) begin
            r = LEN_W'(1);
        end else if (len > LEN_W'(PAM_MAX)) begin
            r = LEN_W'(PAM_MAX);
        end
        return r;
    endfunction

    function automatic logic sym_match(input logic [BASE_W-1:0] sym,
                                       input logic [BASE_W-1:0] b);
        logic m;
        if (sym == SYM_ANY) begin
            m = 1'b1;
        end else if (sym < SYM_ANY) begin
            m = (sym == b);
        end else begin
            m = 1'b0;
        end
        return m;
    endfunction

endpackage

// File: sv/pscan_front.sv
// Front end: takes input requests, keeps the base window, fill and position.
// Depends on pscan_pkg.
module pscan_front import pscan_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [BASE_W-1:0] i_base,
    output logic              o_push,
    output t_slot             o_slot
);

    t_window           r_window, n_window;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [POS_W-1:0]  r_pos, n_pos;

    always_comb begin
        n_window = r_window;
        n_fill   = r_fill;
        n_pos    = r_pos;
        if (i_accept) begin
            if (i_kind == KIND_START) begin
                n_window = '0;
                n_fill   = '0;
                n_pos    = '0;
            end else begin
                n_window = {r_window[WIN_DEPTH-2:0], i_base};
                n_fill   = (r_fill < FILL_MAX) ? r_fill + FILL_W'(1) : r_fill;
                n_pos    = (r_pos < POS_MAX) ? r_pos + POS_W'(1) : r_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
            r_pos    <= '0;
        end else begin
            r_window <= n_window;
            r_fill   <= n_fill;
            r_pos    <= n_pos;
        end
    end

    assign o_push        = i_accept && (i_kind == KIND_BASE);
    assign o_slot.window = n_window;
    assign o_slot.fill   = n_fill;
    assign o_slot.pos    = n_pos;

endmodule

// File: sv/pscan_fifo.sv
// Short slot queue between the front and back ends.
// Depends on pscan_pkg.
module pscan_fifo import pscan_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_slot     i_slot,
    input  logic      i_pop,
    output t_slot     o_slot,
    output t_q_status o_status
);

    t_slot               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                do_push, do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.count = r_count;

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    assign o_slot = r_mem[r_rd_ptr];

endmodule

// File: sv/pscan_back.sv
// Back end: PAM compare and guide extraction on the queue head, result register.
// Depends on pscan_pkg.
module pscan_back import pscan_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LEN_W-1:0]   i_pam_length,
    input  logic [SYMS_W-1:0]  i_pam_symbols,
    input  t_slot              i_slot,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [POS_W-1:0]   o_guide_start,
    output logic [GUIDE_W-1:0] o_guide_bases
);

    logic [LEN_W-1:0]       len;
    logic                   pam_ok, fill_ok, hit, load;
    logic [4:0]             shamt;
    t_window                shifted;
    logic [GUIDE_W-1:0]     guide;
    logic [POS_W-1:0]       start;
    logic                   r_valid;
    logic [POS_W-1:0]       r_start;
    logic [GUIDE_W-1:0]     r_bases;

    always_comb begin
        logic [LEN_W-1:0]  idx;
        logic [BASE_W-1:0] sym;
        len    = eff_pam_len(i_pam_length);
        pam_ok = 1'b1;
        for (int i = 0; i < PAM_MAX; i++) begin
            idx = len - LEN_W'(1) - LEN_W'(i);
            sym = i_pam_symbols[BASE_W*i +: BASE_W];
            if ((LEN_W'(i) < len) && !sym_match(sym, i_slot.window[idx[2:0]])) begin
                pam_ok = 1'b0;
            end
        end
        fill_ok = ({1'b0, i_slot.fill} >= (6'(GUIDE_LEN) + 6'(len)));
        shamt   = 5'(len) * 5'd3;
        shifted = i_slot.window >> shamt;
        for (int i = 0; i < GUIDE_LEN; i++) begin
            guide[BASE_W*i +: BASE_W] = shifted[GUIDE_LEN-1-i];
        end
        start = i_slot.pos - POS_W'(len) - POS_W'(GUIDE_LEN);
    end

    assign hit     = pam_ok && fill_ok;
    assign o_q_pop = !i_q_empty && (!hit || !r_valid || i_pop);
    assign load    = o_q_pop && hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_start <= start;
            r_bases <= guide;
        end
    end

    assign o_empty       = !r_valid;
    assign o_guide_start = r_start;
    assign o_guide_bases = r_bases;

endmodule

// File: sv/pam_site_guide_scanner_core.sv
// PAM site guide scanner top level: config registers, front end, queue, back end.
// An accepted base request is written into the queue, then compared at its head and loaded into the result register.
// Throughput: one request per cycle while full is low, set by the combinational window compare.
// full rises only when the four-slot queue fills behind a stalled result.
// Reset (synchronous, active low) clears window, counts and queue; PAM config
// returns to length 3, pattern NGG. No clearing pass.
module pam_site_guide_scanner_core import pscan_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_kind,
    input  logic [BASE_W-1:0]    i_base,
    output logic                 empty,
    input  logic                 pop,
    output logic [POS_W-1:0]     o_guide_start,
    output logic [GUIDE_W-1:0]   o_guide_bases,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [LEN_W-1:0]  r_pam_length;
    logic [SYMS_W-1:0] r_pam_symbols;
    logic              accept, f_push, q_pop;
    t_slot             f_slot, q_slot;
    t_q_status         q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pam_length  <= PAM_LEN_RST;
            r_pam_symbols <= PAM_SYMS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAM_LENGTH:  r_pam_length  <= i_cfg_data[LEN_W-1:0];
                CFG_PAM_SYMBOLS: r_pam_symbols <= i_cfg_data[SYMS_W-1:0];
            endcase
        end
    end

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    pscan_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_kind   (i_kind),
        .i_base   (i_base),
        .o_push   (f_push),
        .o_slot   (f_slot)
    );

    pscan_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_slot   (f_slot),
        .i_pop    (q_pop),
        .o_slot   (q_slot),
        .o_status (q_status)
    );

    pscan_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pam_length  (r_pam_length),
        .i_pam_symbols (r_pam_symbols),
        .i_slot        (q_slot),
        .i_q_empty     (q_status.empty),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_guide_start (o_guide_start),
        .o_guide_bases (o_guide_bases)
    );

`ifndef NO_ASSERTIONS
    a_full_count: assert property (@(posedge i_clk)
        q_status.full |-> (q_status.count == Q_CNT_W'(Q_DEPTH)))
        else $error("queue full flag disagrees with count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present after reset");

    a_result_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(!q_status.empty))
        else $error("result appeared with queue empty");

    a_start_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == KIND_START)) |=> (q_status.count <= $past(q_status.count)))
        else $error("sequence start request queued a slot");
`endif

endmodule
